// File: design/pmi_pkg.sv
// Shared constants and types for the particle motion integrator.
`default_nettype none

package pmi_pkg;

	// stream word widths, fields packed from bit 0 up, padded to bytes
	localparam int IN_W  = 280;
	localparam int OUT_W = 248;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// saturation bound of the clamped intermediate magnitudes (2^62 - 1)
	localparam logic [61:0] WIDE_MAX = {62{1'b1}};

	// configuration register indexes
	typedef enum logic [CFG_AW-1:0] {
		CFG_TIME_STEP = 3'd0,
		CFG_EXT_ACC_X = 3'd1,
		CFG_EXT_ACC_Y = 3'd2,
		CFG_EXT_ACC_Z = 3'd3,
		CFG_DRAG      = 3'd4,
		CFG_FRICTION  = 3'd5
	} cfg_idx_t;

endpackage

`default_nettype wire

// File: design/particle_motion_integrator_core.sv
// Top level: pipelined particle integrator with drag, friction and saturation.
//
//  channel  | direction | payload
//  s_*      | in        | tdata: pos_x,pos_y,pos_z,vel_x,vel_y,vel_z,head_x,head_y,head_z,thrust
//  m_*      | out       | tdata: new_pos_x..z, new_vel_x..z, new_head_x..z
//  cfg_*    | in        | write enable, register index, data
//
// One particle per cycle while the output buffer is not full. After the input
// and squaring stages come 8 stages of square root (4 root digits each), then one
// stage per 4 quotient bits of the heading divide, then the multiply chain.
// Reset clears the configuration registers, the stage valid bits and the
// output buffer pointers; no clearing pass. A 2-entry buffer holds finished
// transactions; the pipeline freezes and s_tready drops only while it is full.
`default_nettype none

module particle_motion_integrator_core import pmi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, head_x, head_y, head_z, thrust
	input  wire logic [IN_W-1:0]   s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
	// new_head_x, new_head_y, new_head_z
	output logic [OUT_W-1:0]       m_tdata,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	localparam int F   = FRAC_BITS;
	localparam int HW  = (F + 2 > 18) ? F + 2 : 18;
	localparam int PW  = HW + 62;
	localparam int DS  = (F + 4) / 4;
	localparam int SQ0 = 3;
	localparam int SQN = 8;
	localparam int DV0 = SQ0 + SQN;
	localparam int HD  = DV0 + DS;
	localparam int NS  = HD + 8;

	typedef struct packed {
		logic [2:0][31:0]     pos;
		logic [2:0][31:0]     vel;
		logic [2:0][17:0]     hin;
		logic [31:0]          thrust;
		logic [2:0][31:0]     vmag;
		logic [2:0][63:0]     sq;
		logic [61:0]          hd2;
		logic [63:0]          sumsq;
		logic                 nz;
		logic [63:0]          rad;
		logic [33:0]          rem;
		logic [31:0]          root;
		logic [62:0]          dpl;
		logic [62:0]          dph;
		logic [94:0]          dprod;
		logic [61:0]          dterm;
		logic [61:0]          accm;
		logic                 accn;
		logic [2:0][32:0]     dr;
		logic [2:0][F:0]      dq;
		logic                 hsel;
		logic [2:0][HW-1:0]   head;
		logic [2:0][HW-1:0]   hm;
		logic [2:0]           hn;
		logic [2:0][31:0]     f1;
		logic [2:0][62:0]     fm;
		logic [2:0][HW+30:0]  hpl;
		logic [2:0][HW+30:0]  hph;
		logic [2:0][31:0]     velf;
		logic [2:0][61:0]     htm;
		logic [2:0]           htn;
		logic [2:0][62:0]     ptp;
		logic [2:0][61:0]     am;
		logic [2:0]           an;
		logic [2:0][63:0]     pos1;
		logic [2:0][61:0]     pa0;
		logic [2:0][61:0]     pa1;
		logic [2:0][61:0]     pa2;
		logic [2:0][61:0]     pa3;
		logic [2:0][61:0]     pv0;
		logic [2:0][61:0]     pv1;
		logic [2:0][123:0]    pas;
		logic [2:0][92:0]     pvs;
		logic [2:0][62:0]     tp;
		logic [2:0][62:0]     tv;
		logic [2:0][31:0]     opos;
		logic [2:0][31:0]     ovel;
		logic [2:0][17:0]     ohd;
	} item_t;

	// configuration registers
	logic [30:0]      time_step_q;
	logic [2:0][31:0] ext_q;
	logic [30:0]      drag_q;
	logic [30:0]      fric_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
			ext_q       <= '0;
			drag_q      <= '0;
			fric_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_TIME_STEP: time_step_q <= cfg_data[30:0];
				CFG_EXT_ACC_X: ext_q[0]    <= cfg_data;
				CFG_EXT_ACC_Y: ext_q[1]    <= cfg_data;
				CFG_EXT_ACC_Z: ext_q[2]    <= cfg_data;
				CFG_DRAG:      drag_q      <= cfg_data[30:0];
				CFG_FRICTION:  fric_q      <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	function automatic logic [31:0] sat32(input logic signed [64:0] v);
		logic [31:0] r;
		r = v[31:0];
		if (v > 65'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -65'sd2147483648)
			r = 32'h8000_0000;
		return r;
	endfunction

	function automatic logic [17:0] sat18(input logic [HW-1:0] h);
		logic [17:0] r;
		r = h[17:0];
		if ($signed(h) > 131071)
			r = 18'h1FFFF;
		else if ($signed(h) < -131072)
			r = 18'h20000;
		return r;
	endfunction

	// work done by stage k on the item coming from stage k-1
	function automatic item_t stage_fn(input int k, input item_t it);
		item_t o;
		logic [35:0] r36;
		logic [35:0] trial;
		logic [33:0] r34;
		logic [F+31:0] pf;
		logic [PW-1:0] hs;
		logic [123:0] sp;
		logic [92:0] sv;
		logic [94:0] sd;
		logic signed [64:0] x;
		logic [64:0] xm;
		logic [31:0] vm;
		logic [62:0] pt;
		logic [61:0] tm;
		logic qb;
		logic nb;
		int d;
		int t;
		o = it;
		// squares of the velocity, dt squared
		if (k == 1) begin
			for (int n = 0; n < 3; n++)
				o.sq[n] = 64'(it.vmag[n]) * 64'(it.vmag[n]);
			o.hd2 = 62'(time_step_q) * 62'(time_step_q);
		end
		// speed squared, dt^2/2, root setup
		if (k == 2) begin
			o.sumsq = it.sq[0] + it.sq[1] + it.sq[2];
			o.nz    = |o.sumsq;
			o.hd2   = it.hd2 >> (F + 1);
			o.rad   = o.sumsq;
			o.rem   = '0;
			o.root  = '0;
		end
		// integer square root, 4 digits per stage
		if (k >= SQ0 && k < SQ0 + SQN) begin
			for (int s = 0; s < 4; s++) begin
				r36   = {o.rem, o.rad[63:62]};
				trial = {2'b00, o.root, 2'b01};
				if (r36 >= trial) begin
					o.rem  = 34'(r36 - trial);
					o.root = {o.root[30:0], 1'b1};
				end else begin
					o.rem  = r36[33:0];
					o.root = {o.root[30:0], 1'b0};
				end
				o.rad = {o.rad[61:0], 2'b00};
			end
		end
		// drag term and acceleration along heading, beside the root
		if (k == SQ0) begin
			o.dpl = 63'(it.sumsq[31:0]) * 63'(drag_q);
			o.dph = 63'(it.sumsq[63:32]) * 63'(drag_q);
		end
		if (k == SQ0 + 1)
			o.dprod = 95'(it.dpl) + (95'(it.dph) << 32);
		if (k == SQ0 + 2) begin
			sd      = it.dprod >> (2 * F + 1);
			o.dterm = (|sd[94:62]) ? WIDE_MAX : sd[61:0];
		end
		if (k == SQ0 + 3) begin
			x  = 65'($signed(it.thrust)) - $signed({3'b000, it.dterm});
			xm = x;
			if (x[64])
				xm = -xm;
			o.accn = x[64];
			o.accm = (|xm[64:62]) ? WIDE_MAX : xm[61:0];
		end
		// heading divide |v| * 2^F / speed, 4 quotient bits per stage
		if (k >= DV0 && k < DV0 + DS) begin
			d = k - DV0;
			for (int n = 0; n < 3; n++) begin
				if (d == 0) begin
					o.dr[n] = {2'b00, it.vmag[n][31:1]};
					o.dq[n] = '0;
				end
				for (int s = 0; s < 4; s++) begin
					t = 4 * d + s;
					if (t <= F) begin
						nb  = (t == 0) ? it.vmag[n][0] : 1'b0;
						r34 = {o.dr[n], nb};
						qb  = r34 >= {2'b00, o.root};
						if (qb)
							r34 = r34 - {2'b00, o.root};
						o.dr[n] = r34[32:0];
						o.dq[n] = {o.dq[n][F-1:0], qb};
					end
				end
			end
		end
		// heading select, friction per unit time
		if (k == HD) begin
			o.hsel = (time_step_q == '0) || !it.nz;
			for (int n = 0; n < 3; n++) begin
				if (o.hsel) begin
					o.head[n] = HW'($signed(it.hin[n]));
				end else begin
					o.head[n] = HW'(it.dq[n]);
					if (it.vel[n][31])
						o.head[n] = -o.head[n];
				end
				o.hn[n] = o.head[n][HW-1];
				o.hm[n] = o.hn[n] ? -o.head[n] : o.head[n];
				pf      = (F + 32)'(it.dq[n]) * (F + 32)'(fric_q);
				o.f1[n] = 32'(pf >> F);
			end
		end
		// friction over dt, heading times acceleration partials
		if (k == HD + 1) begin
			for (int n = 0; n < 3; n++) begin
				pt       = 63'(it.f1[n]) * 63'(time_step_q);
				o.fm[n]  = pt >> F;
				o.hpl[n] = (HW + 31)'(it.hm[n]) * (HW + 31)'(it.accm[30:0]);
				o.hph[n] = (HW + 31)'(it.hm[n]) * (HW + 31)'(it.accm[61:31]);
			end
		end
		// friction clamp toward zero, heading term
		if (k == HD + 2) begin
			for (int n = 0; n < 3; n++) begin
				vm = '0;
				if (63'(it.vmag[n]) > it.fm[n])
					vm = it.vmag[n] - it.fm[n][31:0];
				o.velf[n] = it.vel[n][31] ? -vm : vm;
				hs        = PW'(it.hpl[n]) + (PW'(it.hph[n]) << 31);
				hs        = hs >> F;
				o.htm[n]  = (|hs[PW-1:62]) ? WIDE_MAX : hs[61:0];
				o.htn[n]  = it.hn[n] ^ it.accn;
			end
		end
		// v*dt product, total acceleration
		if (k == HD + 3) begin
			for (int n = 0; n < 3; n++) begin
				vm       = it.velf[n][31] ? -it.velf[n] : it.velf[n];
				o.ptp[n] = 63'(vm) * 63'(time_step_q);
				x        = 65'($signed(ext_q[n]));
				if (it.htn[n])
					x = x - $signed({3'b000, it.htm[n]});
				else
					x = x + $signed({3'b000, it.htm[n]});
				xm = x;
				if (x[64])
					xm = -xm;
				o.an[n] = x[64];
				o.am[n] = (|xm[64:62]) ? WIDE_MAX : xm[61:0];
			end
		end
		// position plus v*dt, acceleration partial products
		if (k == HD + 4) begin
			for (int n = 0; n < 3; n++) begin
				pt = it.ptp[n] >> F;
				x  = 65'($signed(it.pos[n]));
				if (it.velf[n][31])
					x = x - $signed({2'b00, pt});
				else
					x = x + $signed({2'b00, pt});
				o.pos1[n] = x[63:0];
				o.pa0[n]  = 62'(it.am[n][30:0]) * 62'(it.hd2[30:0]);
				o.pa1[n]  = 62'(it.am[n][30:0]) * 62'(it.hd2[61:31]);
				o.pa2[n]  = 62'(it.am[n][61:31]) * 62'(it.hd2[30:0]);
				o.pa3[n]  = 62'(it.am[n][61:31]) * 62'(it.hd2[61:31]);
				o.pv0[n]  = 62'(it.am[n][30:0]) * 62'(time_step_q);
				o.pv1[n]  = 62'(it.am[n][61:31]) * 62'(time_step_q);
			end
		end
		// partial product sums
		if (k == HD + 5) begin
			for (int n = 0; n < 3; n++) begin
				o.pas[n] = 124'(it.pa0[n]) + (124'(it.pa1[n]) << 31)
					+ (124'(it.pa2[n]) << 31) + (124'(it.pa3[n]) << 62);
				o.pvs[n] = 93'(it.pv0[n]) + (93'(it.pv1[n]) << 31);
			end
		end
		// scale, clamp and sign the two acceleration terms
		if (k == HD + 6) begin
			for (int n = 0; n < 3; n++) begin
				sp      = it.pas[n] >> F;
				tm      = (|sp[123:62]) ? WIDE_MAX : sp[61:0];
				o.tp[n] = it.an[n] ? -{1'b0, tm} : {1'b0, tm};
				sv      = it.pvs[n] >> F;
				tm      = (|sv[92:62]) ? WIDE_MAX : sv[61:0];
				o.tv[n] = it.an[n] ? -{1'b0, tm} : {1'b0, tm};
			end
		end
		// final sums and output saturation
		if (k == HD + 7) begin
			for (int n = 0; n < 3; n++) begin
				x         = 65'($signed(it.pos1[n])) + 65'($signed(it.tp[n]));
				o.opos[n] = sat32(x);
				x         = 65'($signed(it.velf[n])) + 65'($signed(it.tv[n]));
				o.ovel[n] = sat32(x);
				o.ohd[n]  = it.hsel ? it.hin[n] : sat18(it.head[n]);
			end
		end
		return o;
	endfunction

	item_t      st  [NS];
	item_t      nxt [NS];
	logic [NS-1:0] v_q;
	logic       en;
	logic       push;
	logic       pop;

	// output buffer
	logic [OUT_W-1:0] ob_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;
	assign push     = en && v_q[NS-1];
	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = ob_q[rp_q];

	// unpack the input transaction
	always_comb begin
		nxt[0] = '0;
		for (int n = 0; n < 3; n++) begin
			nxt[0].pos[n]  = s_tdata[32*n +: 32];
			nxt[0].vel[n]  = s_tdata[96 + 32*n +: 32];
			nxt[0].hin[n]  = s_tdata[192 + 18*n +: 18];
			nxt[0].vmag[n] = nxt[0].vel[n][31] ? -nxt[0].vel[n] : nxt[0].vel[n];
		end
		nxt[0].thrust = s_tdata[277:246];
	end

	for (genvar k = 1; k < NS; k++) begin : g_stage
		always_comb nxt[k] = stage_fn(k, st[k-1]);
	end

	// stage registers, all advance together
	for (genvar k = 0; k < NS; k++) begin : g_reg
		always_ff @(posedge clk) begin
			if (en)
				st[k] <= nxt[k];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-2:0], s_tvalid};
		end
	end

	// output buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ob_q[wp_q] <= {2'b00,
				st[NS-1].ohd[2], st[NS-1].ohd[1], st[NS-1].ohd[0],
				st[NS-1].ovel[2], st[NS-1].ovel[1], st[NS-1].ovel[0],
				st[NS-1].opos[2], st[NS-1].opos[1], st[NS-1].opos[0]};
	end

endmodule

`default_nettype wire

// File: design/pmi_checker.sv
// Port-level checks of the particle integrator, bound to the top level.
`default_nettype none

module pmi_checker import pmi_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	// held result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn before it was taken");

	// held result keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// input back-pressure only with results waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// a full buffer stays full until drained
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && !m_tready |=> !s_tready)
		else $error("input reopened without a result leaving");

endmodule

bind particle_motion_integrator_core pmi_checker u_pmi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
